/* sv/multitouch_slot_tracker_defines.svh */
// Assertion macros shared by the multitouch slot tracker RTL.
`ifndef MULTITOUCH_SLOT_TRACKER_DEFINES_SVH
`define MULTITOUCH_SLOT_TRACKER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define MTS_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/mts_pkg.sv */
// Types and constants of the multitouch slot tracker.
`timescale 1ns / 1ps
package mts_pkg;

    typedef enum logic [2:0] {
        CMD_SLOT   = 3'd0,
        CMD_TRACK  = 3'd1,
        CMD_MTX    = 3'd2,
        CMD_MTY    = 3'd3,
        CMD_STX    = 3'd4,
        CMD_STY    = 3'd5,
        CMD_BUTTON = 3'd6,
        CMD_SYNC   = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD_WR,
        ST_SRCH,
        ST_SRCH_WR,
        ST_RPT_SCAN,
        ST_RPT_LOAD,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic clr;
        logic cmp;
    } srch_ctl_t;

    localparam int          COORD_W    = 32;
    localparam int          PREV_W     = 5;
    localparam logic [3:0]  MAX_REPORT = 4'd10;
    localparam logic [3:0]  SHOW_MAX   = 4'd15;

endpackage

/* sv/mts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/mts_id_search.sv */
// Tracking id search: last matching slot, else first free slot, else last slot.
`timescale 1ns / 1ps
module mts_id_search
    import mts_pkg::*;
#(
    parameter int SLOTS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  srch_ctl_t                ctl,
    input  logic [$clog2(SLOTS)-1:0] idx,
    input  logic [31:0]              key,
    input  logic [31:0]              id_data,
    output logic [$clog2(SLOTS)-1:0] slot
);

    localparam int IW = $clog2(SLOTS);

    logic          match_found_reg, match_found_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    always_comb
    begin
        match_found_next = match_found_reg;
        free_found_next  = free_found_reg;
        match_idx_next   = match_idx_reg;
        free_idx_next    = free_idx_reg;
        if (ctl.clr)
        begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else if (ctl.cmp)
        begin
            // later match overrides an earlier one
            if (id_data == key)
            begin
                match_found_next = 1'b1;
                match_idx_next   = idx;
            end
            if (id_data[31] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
    end

    assign slot = match_found_reg ? match_idx_reg :
                  free_found_reg  ? free_idx_reg  : IW'(SLOTS - 1);

endmodule

/* sv/multitouch_slot_tracker.sv */
// Multitouch slot tracker: per-slot touch state in RAM and frame reports on sync.
//
// Input channel (in_valid/in_stall, cmd/value): one touch event per beat. Events are
// taken only while the block is idle; in_stall is high while an event is at work.
// - slot select, release, button: done in idle, next event may follow directly.
// - coordinate writes: read-modify-write of the shared X/Y entry (ST_COORD_WR).
// - new tracking id without slot events: a walk through the tracking id RAM, one
//   entry per cycle (ST_SRCH), then the id write (ST_SRCH_WR).
// - sync: released slots are passed over, each reported slot takes a RAM read, then
//   an output load; an empty frame gives one beat from ST_EMPTY.
// Output channel (out_valid/out_stall): one beat per reported slot in index order,
// last_of_frame on the final beat. Results sit in an output register, so a new event
// is taken while the last beat of a frame still waits. A stalled receiver holds
// the beat and pauses the report walk; nothing is dropped.
// Reset: all slots released, ids free, coordinates zero, slot 0 current, and the
// first frame always flags a count change. Valid bits stand in for the RAM
// contents after reset, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "multitouch_slot_tracker_defines.svh"
module multitouch_slot_tracker
    import mts_pkg::*;
#(
    parameter int SLOTS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         slot_index,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic               slot_valid,
    output logic [3:0]         active_count,
    output logic               count_changed,
    output logic               last_of_frame
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    state_t state_reg, state_next;

    cmd_t               cmd_reg, cmd_next;
    logic [31:0]        val_reg, val_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic               seen_reg, seen_next;
    logic [SLOTS-1:0]   pressed_reg, pressed_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [SLOTS-1:0]   xy_vld_reg, xy_vld_next;
    logic [SLOTS-1:0]   id_vld_reg, id_vld_next;
    logic [PREV_W-1:0]  prev_reg, prev_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]      wa_reg, wa_next;
    logic [3:0]         total_reg, total_next;
    logic [3:0]         shown_reg, shown_next;
    logic               chg_reg, chg_next;
    logic [3:0]         emit_reg, emit_next;

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         slot_index_reg, slot_index_next;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic               slot_valid_reg, slot_valid_next;
    logic [3:0]         active_count_reg, active_count_next;
    logic               count_changed_reg, count_changed_next;
    logic               last_reg, last_next;

    logic                 c_we, c_re;
    logic [IW-1:0]        c_waddr, c_raddr;
    logic [2*COORD_W-1:0] c_wdata, c_rdata, c_base;
    logic                 i_we, i_re;
    logic [IW-1:0]        i_waddr, i_raddr;
    logic [31:0]          i_wdata, i_rdata, id_eff;

    srch_ctl_t     srch_ctl;
    logic [IW-1:0] srch_slot;

    logic              in_acc;
    logic              out_free;
    logic              out_load;
    logic              last_beat;
    logic [IW-1:0]     sidx;
    logic [IW-1:0]     slot_sel;
    logic [PREV_W-1:0] n5;
    logic              p_we, p_val;
    logic [IW-1:0]     p_idx;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sidx      = idx_reg[IW-1:0];
    assign last_beat = ((emit_reg + 4'd1) == total_reg);
    assign n5        = PREV_W'(cnt_reg);
    assign slot_sel  = (!value[31] && ($unsigned(value) < 32'(SLOTS))) ?
                       value[IW-1:0] : IW'(SLOTS - 1);
    assign c_base    = xy_vld_reg[wa_reg] ? c_rdata : '0;
    // an entry never written reads as a free id
    assign id_eff    = id_vld_reg[cmp_idx_reg] ? i_rdata : '1;

    mts_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (SLOTS)
    ) u_coord_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    mts_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_id_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .re    (i_re),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    mts_id_search #(
        .SLOTS (SLOTS)
    ) u_id_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (srch_ctl),
        .idx     (cmp_idx_reg),
        .key     (val_reg),
        .id_data (id_eff),
        .slot    (srch_slot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_TRACK:
                        begin
                            if (!value[31] && !seen_reg)
                            begin
                                state_next = ST_SRCH;
                            end
                        end
                        CMD_MTX, CMD_MTY, CMD_STX, CMD_STY:
                        begin
                            state_next = ST_COORD_WR;
                        end
                        CMD_SYNC:
                        begin
                            state_next = (cnt_reg == '0) ? ST_EMPTY : ST_RPT_SCAN;
                        end
                        CMD_SLOT, CMD_BUTTON:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_COORD_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_SRCH:
            begin
                if (idx_reg == CW'(SLOTS) && cmp_vld_reg)
                begin
                    state_next = ST_SRCH_WR;
                end
            end
            ST_SRCH_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_RPT_SCAN:
            begin
                if (pressed_reg[sidx])
                begin
                    state_next = ST_RPT_LOAD;
                end
            end
            ST_RPT_LOAD:
            begin
                if (out_free)
                begin
                    state_next = last_beat ? ST_IDLE : ST_RPT_SCAN;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cmd_next           = cmd_reg;
        val_next           = val_reg;
        cur_next           = cur_reg;
        seen_next          = seen_reg;
        pressed_next       = pressed_reg;
        cnt_next           = cnt_reg;
        xy_vld_next        = xy_vld_reg;
        id_vld_next        = id_vld_reg;
        prev_next          = prev_reg;
        idx_next           = idx_reg;
        cmp_vld_next       = 1'b0;
        cmp_idx_next       = cmp_idx_reg;
        wa_next            = wa_reg;
        total_next         = total_reg;
        shown_next         = shown_reg;
        chg_next           = chg_reg;
        emit_next          = emit_reg;
        slot_index_next    = slot_index_reg;
        pos_x_next         = pos_x_reg;
        pos_y_next         = pos_y_reg;
        slot_valid_next    = slot_valid_reg;
        active_count_next  = active_count_reg;
        count_changed_next = count_changed_reg;
        last_next          = last_reg;
        out_load           = 1'b0;
        c_we               = 1'b0;
        c_re               = 1'b0;
        c_waddr            = wa_reg;
        c_raddr            = sidx;
        c_wdata            = c_base;
        i_we               = 1'b0;
        i_re               = 1'b0;
        i_waddr            = srch_slot;
        i_raddr            = sidx;
        i_wdata            = val_reg;
        srch_ctl           = '{clr: 1'b0, cmp: 1'b0};
        p_we               = 1'b0;
        p_val              = 1'b0;
        p_idx              = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next = cmd_t'(cmd);
                    val_next = value;
                    unique case (cmd_t'(cmd))
                        CMD_SLOT:
                        begin
                            seen_next = 1'b1;
                            cur_next  = slot_sel;
                        end
                        CMD_TRACK:
                        begin
                            if (value[31])
                            begin
                                p_we  = 1'b1;
                                p_val = 1'b0;
                                if (!seen_reg)
                                begin
                                    id_vld_next[cur_reg] = 1'b0;
                                end
                            end
                            else if (seen_reg)
                            begin
                                p_we  = 1'b1;
                                p_val = 1'b1;
                            end
                            else
                            begin
                                idx_next     = '0;
                                srch_ctl.clr = 1'b1;
                            end
                        end
                        CMD_MTX, CMD_MTY:
                        begin
                            c_re    = 1'b1;
                            c_raddr = cur_reg;
                            wa_next = cur_reg;
                        end
                        CMD_STX, CMD_STY:
                        begin
                            c_re    = 1'b1;
                            c_raddr = '0;
                            wa_next = '0;
                        end
                        CMD_BUTTON:
                        begin
                            p_we  = 1'b1;
                            p_idx = '0;
                            p_val = (value != '0);
                        end
                        CMD_SYNC:
                        begin
                            chg_next   = (n5 != prev_reg);
                            prev_next  = n5;
                            shown_next = (n5 > PREV_W'(SHOW_MAX)) ? SHOW_MAX : n5[3:0];
                            total_next = (n5 > PREV_W'(MAX_REPORT)) ? MAX_REPORT : n5[3:0];
                            idx_next   = '0;
                            emit_next  = '0;
                        end
                    endcase
                end
            end
            ST_COORD_WR:
            begin
                c_we = 1'b1;
                if (cmd_reg == CMD_MTX || cmd_reg == CMD_STX)
                begin
                    c_wdata = {val_reg, c_base[COORD_W-1:0]};
                end
                else
                begin
                    c_wdata = {c_base[2*COORD_W-1:COORD_W], val_reg};
                end
                xy_vld_next[wa_reg] = 1'b1;
            end
            ST_SRCH:
            begin
                // issue one read per cycle, compare it in the next
                srch_ctl.cmp = cmp_vld_reg;
                if (idx_reg < CW'(SLOTS))
                begin
                    i_re         = 1'b1;
                    i_raddr      = sidx;
                    idx_next     = idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = sidx;
                end
            end
            ST_SRCH_WR:
            begin
                i_we                   = 1'b1;
                id_vld_next[srch_slot] = 1'b1;
                cur_next               = srch_slot;
                p_we                   = 1'b1;
                p_idx                  = srch_slot;
                p_val                  = 1'b1;
            end
            ST_RPT_SCAN:
            begin
                if (pressed_reg[sidx])
                begin
                    c_re = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_RPT_LOAD:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    slot_index_next    = 4'(idx_reg);
                    pos_x_next         = xy_vld_reg[sidx] ? c_rdata[2*COORD_W-1:COORD_W] : '0;
                    pos_y_next         = xy_vld_reg[sidx] ? c_rdata[COORD_W-1:0] : '0;
                    slot_valid_next    = 1'b1;
                    active_count_next  = shown_reg;
                    count_changed_next = chg_reg;
                    last_next          = last_beat;
                    emit_next          = emit_reg + 4'd1;
                    idx_next           = idx_reg + CW'(1);
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    slot_index_next    = '0;
                    pos_x_next         = '0;
                    pos_y_next         = '0;
                    slot_valid_next    = 1'b0;
                    active_count_next  = '0;
                    count_changed_next = chg_reg;
                    last_next          = 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        // keep the pressed count in step with the flags
        if (p_we)
        begin
            pressed_next[p_idx] = p_val;
            if (p_val && !pressed_reg[p_idx])
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else if (!p_val && pressed_reg[p_idx])
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            seen_reg      <= 1'b0;
            pressed_reg   <= '0;
            cnt_reg       <= '0;
            xy_vld_reg    <= '0;
            id_vld_reg    <= '0;
            prev_reg      <= '1;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            emit_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            seen_reg      <= seen_next;
            pressed_reg   <= pressed_next;
            cnt_reg       <= cnt_next;
            xy_vld_reg    <= xy_vld_next;
            id_vld_reg    <= id_vld_next;
            prev_reg      <= prev_next;
            idx_reg       <= idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            emit_reg      <= emit_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        val_reg           <= val_next;
        cmp_idx_reg       <= cmp_idx_next;
        wa_reg            <= wa_next;
        shown_reg         <= shown_next;
        chg_reg           <= chg_next;
        slot_index_reg    <= slot_index_next;
        pos_x_reg         <= pos_x_next;
        pos_y_reg         <= pos_y_next;
        slot_valid_reg    <= slot_valid_next;
        active_count_reg  <= active_count_next;
        count_changed_reg <= count_changed_next;
        last_reg          <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign slot_index    = slot_index_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign slot_valid    = slot_valid_reg;
    assign active_count  = active_count_reg;
    assign count_changed = count_changed_reg;
    assign last_of_frame = last_reg;

    `MTS_ASSERT_ALWAYS(a_cnt_matches_flags, $countones(pressed_reg) == int'(cnt_reg), "pressed count out of step with flags")
    `MTS_ASSERT_ALWAYS(a_cur_in_range, int'(cur_reg) < SLOTS, "current slot out of range")
    `MTS_ASSERT_ALWAYS(a_emit_bounded, emit_reg <= total_reg, "more beats reported than slots in frame")
    `MTS_ASSERT_IMP(a_load_pressed, state_reg == ST_RPT_LOAD, pressed_reg[sidx], "report load on a released slot")
    `MTS_ASSERT_IMP(a_valid_nonzero, out_valid_reg && slot_valid_reg, active_count_reg != 4'd0, "slot beat with zero active count")

endmodule

/* sim/testbench.sv */
// Testbench for the multitouch slot tracker: directed and random touch events, checked frames.
`timescale 1ns / 1ps
module testbench;
    import mts_pkg::*;

    localparam int SLOTS = 10;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic        valid;
        logic [3:0]  count;
        logic        changed;
        logic        last;
    } report_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    cmd_t               cmd = CMD_SLOT;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [3:0]         slot_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               slot_valid;
    logic [3:0]         active_count;
    logic               count_changed;
    logic               last_of_frame;

    multitouch_slot_tracker #(.SLOTS(SLOTS)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot_index   (slot_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .slot_valid   (slot_valid),
        .active_count (active_count),
        .count_changed(count_changed),
        .last_of_frame(last_of_frame)
    );

    always #6 clk = ~clk;

    // Shadow copy of the touch state.
    logic [3:0]  sh_cur;
    logic        sh_seen;
    logic [31:0] sh_x [SLOTS];
    logic [31:0] sh_y [SLOTS];
    logic        sh_pressed [SLOTS];
    logic [31:0] sh_tid [SLOTS];
    logic [4:0]  sh_prev;

    report_t frame_reports[$];
    int      mismatches = 0;
    int      events_sent = 0;
    bit      calm = 1'b0;
    int      rx_hold = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic track_event(input cmd_t c, input logic [31:0] v);
        int      f;
        int      n;
        int      k;
        logic    chg;
        logic [3:0] s;
        report_t rep;
        s = sh_cur;
        case (c)
            CMD_SLOT:
            begin
                sh_seen = 1'b1;
                sh_cur = (!v[31] && v < SLOTS) ? v[3:0] : 4'(SLOTS - 1);
            end
            CMD_TRACK:
            begin
                if (v[31])
                begin
                    sh_pressed[s] = 1'b0;
                    if (!sh_seen)
                        sh_tid[s] = '1;
                end
                else
                begin
                    if (!sh_seen)
                    begin
                        // Last slot holding the id wins, then first free, then the last slot.
                        f = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (sh_tid[i] == v)
                                f = i;
                        if (f < 0)
                            for (int i = 0; i < SLOTS; i++)
                                if (sh_tid[i][31] && f < 0)
                                    f = i;
                        if (f < 0)
                            f = SLOTS - 1;
                        sh_tid[f] = v;
                        sh_cur = 4'(f);
                        s = 4'(f);
                    end
                    sh_pressed[s] = 1'b1;
                end
            end
            CMD_MTX:    sh_x[s] = v;
            CMD_MTY:    sh_y[s] = v;
            CMD_STX:    sh_x[0] = v;
            CMD_STY:    sh_y[0] = v;
            CMD_BUTTON: sh_pressed[0] = (v != 0);
            default:
            begin
                n = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (sh_pressed[i])
                        n++;
                chg = (n != int'(sh_prev));
                sh_prev = 5'(n);
                if (n == 0)
                begin
                    rep = '{4'd0, 32'd0, 32'd0, 1'b0, 4'd0, chg, 1'b1};
                    frame_reports.push_back(rep);
                end
                else
                begin
                    k = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (sh_pressed[i] && k < int'(MAX_REPORT))
                        begin
                            k++;
                            rep.idx = 4'(i);
                            rep.x = sh_x[i];
                            rep.y = sh_y[i];
                            rep.valid = 1'b1;
                            rep.count = (n > 15) ? SHOW_MAX : 4'(n);
                            rep.changed = chg;
                            rep.last = (k == n || k == int'(MAX_REPORT));
                            frame_reports.push_back(rep);
                        end
                end
            end
        endcase
    endtask

    // Offer one beat after a random gap, hold it until taken, then predict.
    task automatic send_event(input cmd_t c, input logic [31:0] v);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        cmd = c;
        value = v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_event(c, v);
        events_sent++;
    endtask

    // Receiver: random stall stretches, set at the falling edge.
    always @(negedge clk)
    begin
        if (rx_hold == 0)
            rx_hold = calm ? 0 : gap_len();
        out_stall = (rx_hold != 0);
        if (rx_hold != 0)
            rx_hold--;
    end

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_reports.size() == 0)
            begin
                $error("result beat with nothing expected: slot_index %0d", slot_index);
                mismatches++;
            end
            else
            begin
                want = frame_reports.pop_front();
                if (slot_index !== want.idx)
                begin
                    $error("slot_index expected %0d got %0d", want.idx, slot_index);
                    mismatches++;
                end
                if (pos_x !== want.x)
                begin
                    $error("pos_x expected %h got %h", want.x, pos_x);
                    mismatches++;
                end
                if (pos_y !== want.y)
                begin
                    $error("pos_y expected %h got %h", want.y, pos_y);
                    mismatches++;
                end
                if (slot_valid !== want.valid)
                begin
                    $error("slot_valid expected %0d got %0d", want.valid, slot_valid);
                    mismatches++;
                end
                if (active_count !== want.count)
                begin
                    $error("active_count expected %0d got %0d", want.count, active_count);
                    mismatches++;
                end
                if (count_changed !== want.changed)
                begin
                    $error("count_changed expected %0d got %0d", want.changed, count_changed);
                    mismatches++;
                end
                if (last_of_frame !== want.last)
                begin
                    $error("last_of_frame expected %0d got %0d", want.last, last_of_frame);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 11);
        else if (r < 92)
            return $urandom;
        return -$urandom_range(1, 5);
    endfunction

    function automatic logic [31:0] pick_slot();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, SLOTS - 1);
    endfunction

    task automatic test_empty_frame();
        send_event(CMD_SYNC, 32'd0);
        send_event(CMD_SYNC, 32'hFFFF_FFFF);
    endtask

    // Anonymous protocol: id reuse, release, single-touch and button paths.
    task automatic test_anonymous_ids();
        send_event(CMD_TRACK, 32'd0);
        send_event(CMD_MTX, 32'h7FFF_FFFF);
        send_event(CMD_MTY, 32'h8000_0000);
        send_event(CMD_TRACK, 32'h7FFF_FFFF);
        send_event(CMD_TRACK, 32'd0);
        send_event(CMD_SYNC, 32'd0);
        send_event(CMD_TRACK, 32'hFFFF_FFFF);
        send_event(CMD_STX, 32'hFFFF_FFFF);
        send_event(CMD_STY, 32'd1);
        send_event(CMD_BUTTON, 32'h8000_0000);
        send_event(CMD_SYNC, 32'd0);
        send_event(CMD_BUTTON, 32'd0);
    endtask

    // Send SLOTS new ids, then a sync; an id without a free slot lands on the last slot.
    task automatic test_slot_overflow();
        for (int i = 0; i < SLOTS; i++)
            send_event(CMD_TRACK, 32'd1000 + i);
        send_event(CMD_SYNC, 32'd0);
    endtask

    task automatic test_random_anonymous(input int count);
        int target;
        int n;
        target = events_sent + count;
        while (events_sent < target)
        begin
            if (events_sent % 20 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 15)
                send_event(cmd_t'($urandom_range(1, 7)), $urandom);
            else
            begin
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    send_event(CMD_TRACK, pick_id());
                    if ($urandom_range(0, 4) == 0)
                        send_event(CMD_TRACK, $urandom | 32'h8000_0000);
                    else
                    begin
                        send_event(CMD_MTX, $urandom);
                        send_event(CMD_MTY, $urandom);
                    end
                end
                send_event(CMD_SYNC, $urandom);
            end
        end
        calm = 1'b0;
    endtask

    // Slot protocol: clamp of bad slot numbers, press without id, release.
    task automatic test_slot_protocol();
        send_event(CMD_SLOT, 32'd0);
        send_event(CMD_TRACK, 32'd5);
        send_event(CMD_SLOT, 32'd10);
        send_event(CMD_MTX, 32'h1234_5678);
        send_event(CMD_SLOT, 32'h8000_0000);
        send_event(CMD_TRACK, 32'hFFFF_FFFF);
        send_event(CMD_SLOT, 32'h7FFF_FFFF);
        send_event(CMD_SYNC, 32'd0);
    endtask

    task automatic test_random_slots(input int count);
        int target;
        int n;
        int r;
        target = events_sent + count;
        while (events_sent < target)
        begin
            if (events_sent % 20 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 15)
                send_event(cmd_t'($urandom_range(0, 7)), $urandom);
            else
            begin
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    send_event(CMD_SLOT, pick_slot());
                    if ($urandom_range(0, 4) == 0)
                        send_event(CMD_TRACK, $urandom | 32'h8000_0000);
                    else
                        send_event(CMD_TRACK, $urandom & 32'h7FFF_FFFF);
                    send_event(CMD_MTX, $urandom);
                    send_event(CMD_MTY, $urandom);
                end
                if (r < 25)
                    send_event(cmd_t'($urandom_range(4, 6)), $urandom_range(0, 1));
                send_event(CMD_SYNC, $urandom);
            end
        end
        calm = 1'b0;
    endtask

    task automatic drain_and_report();
        int w;
        @(negedge clk);
        in_valid = 1'b0;
        w = 0;
        while (frame_reports.size() != 0 && w < 200000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (40) @(posedge clk);
        if (frame_reports.size() != 0)
        begin
            $error("%0d expected result beats never arrived", frame_reports.size());
            mismatches++;
        end
    endtask

    initial
    begin
        sh_cur = '0;
        sh_seen = 1'b0;
        sh_prev = '1;
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_x[i] = '0;
            sh_y[i] = '0;
            sh_pressed[i] = 1'b0;
            sh_tid[i] = '1;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_empty_frame();
        test_anonymous_ids();
        test_slot_overflow();
        // Any slot select ends the anonymous protocol for good, so run it first.
        test_random_anonymous(55);
        test_slot_protocol();
        test_random_slots(65);
        drain_and_report();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/mts_pkg.sv
sv/mts_ram.sv
sv/mts_id_search.sv
sv/multitouch_slot_tracker.sv
sim/testbench.sv
